>>> hw/rtl/gsa_pkg.sv
`default_nettype none

package gsa_pkg;

    // request kinds carried on the input tuser
    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_ALLOC = 2'd0;
    localparam cmd_t CMD_FREE  = 2'd1;
    localparam cmd_t CMD_CHECK = 2'd2;

    // result codes carried on the output tuser
    typedef logic [1:0] status_t;
    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_FULL    = 2'd1;
    localparam status_t STAT_INVALID = 2'd2;

    // free list strobes from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } fl_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/generational_slot_allocator.sv
// Free, check and allocate from fresh slots go from IDLE to EXEC; an allocate that reuses
//   a slot from the free list goes IDLE, FIFO, EXEC (free list read, then slot table read).
//   One request is in flight at a time: EXEC holds its result until the result register is
//   free, and a new input transfer is taken the cycle after the result is registered.
// Reset (aresetn, synchronous, active low) clears the counters and the sequencer at once;
//   the slot table and free list memories need no clearing pass.
`default_nettype none

module generational_slot_allocator #(
    parameter int SLOTS    = 1024,
    parameter int GEN_BITS = 16,
    localparam int IDX_W    = $clog2(SLOTS),
    localparam int CNT_W    = $clog2(SLOTS + 1),
    localparam int S_DATA_W = ((IDX_W + GEN_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((IDX_W + GEN_BITS + CNT_W + 7) / 8) * 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // request channel
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,   // in_index, in_generation, zero pad
    input  wire gsa_pkg::cmd_t       s_axis_tuser,   // cmd
    // result channel
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic      [M_DATA_W-1:0] m_axis_tdata,   // out_index, out_generation,
                                                     // live_count, zero pad
    output gsa_pkg::status_t         m_axis_tuser    // status
);
    import gsa_pkg::*;

    localparam int ENT_W = GEN_BITS + 1;
    localparam logic [GEN_BITS-1:0] GEN_MAX = '1;
    localparam logic [GEN_BITS-1:0] GEN_ONE = GEN_BITS'(1);
    localparam logic [CNT_W-1:0]    SLOTS_C = CNT_W'(SLOTS);

    // sequencer: IDLE takes a request and starts the first read if any, FIFO turns the popped
    // slot index into a slot table read, EXEC decides, writes back and loads the result.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_FIFO = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // latched request
    cmd_t                cmd_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [GEN_BITS-1:0] gen_reg;
    logic                from_fifo_reg, from_fifo_next;

    // counters
    logic [CNT_W-1:0]    hw_reg, hw_next;      // slots ever handed out
    logic [CNT_W-1:0]    live_reg, live_next;  // live handles

    // result register
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg;
    logic [IDX_W-1:0]    m_index_reg;
    logic [GEN_BITS-1:0] m_gen_reg;
    logic [CNT_W-1:0]    m_live_reg;

    // input fields
    logic [IDX_W-1:0]    s_index;
    logic [GEN_BITS-1:0] s_gen;
    logic                s_xfer;

    assign s_index = s_axis_tdata[IDX_W-1:0];
    assign s_gen   = s_axis_tdata[IDX_W +: GEN_BITS];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_xfer  = s_axis_tvalid && s_axis_tready;

    // memories
    fl_ctrl_t            fl_ctrl;
    logic                fl_empty;
    logic [IDX_W-1:0]    fl_pop_idx;

    logic                tab_rd_en;
    logic [IDX_W-1:0]    tab_rd_addr;
    logic [ENT_W-1:0]    tab_rd_data;
    logic                tab_wr_en;
    logic [IDX_W-1:0]    tab_wr_addr;
    logic [ENT_W-1:0]    tab_wr_data;

    gsa_free_list #(
        .SLOTS(SLOTS)
    ) u_free_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fl_ctrl),
        .push_idx(idx_reg),
        .empty   (fl_empty),
        .pop_idx (fl_pop_idx)
    );

    gsa_slot_mem #(
        .SLOTS   (SLOTS),
        .GEN_BITS(GEN_BITS)
    ) u_slot_mem (
        .aclk   (aclk),
        .rd_en  (tab_rd_en),
        .rd_addr(tab_rd_addr),
        .rd_data(tab_rd_data),
        .wr_en  (tab_wr_en),
        .wr_addr(tab_wr_addr),
        .wr_data(tab_wr_data)
    );

    // slot table entry read back for the current request
    logic                ent_active;
    logic [GEN_BITS-1:0] ent_gen;
    logic                live_hit;
    logic                out_free;
    logic [GEN_BITS-1:0] gen_bumped;

    assign ent_active = tab_rd_data[GEN_BITS];
    assign ent_gen    = tab_rd_data[GEN_BITS-1:0];
    // entries at or above the high water mark were never written, so gate on it first
    assign live_hit   = (gen_reg != '0) && (CNT_W'(idx_reg) < hw_reg)
                        && (ent_gen == gen_reg) && ent_active;
    assign gen_bumped = (ent_gen == GEN_MAX) ? GEN_ONE : ent_gen + 1'b1;
    assign out_free   = !m_valid_reg || m_axis_tready;

    // result values computed in EXEC
    status_t             res_status;
    logic [IDX_W-1:0]    res_index;
    logic [GEN_BITS-1:0] res_gen;

    always_comb begin
        state_next     = state_reg;
        from_fifo_next = from_fifo_reg;
        hw_next        = hw_reg;
        live_next      = live_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        fl_ctrl        = '0;
        tab_rd_en      = 1'b0;
        tab_rd_addr    = s_index;
        tab_wr_en      = 1'b0;
        tab_wr_addr    = idx_reg;
        tab_wr_data    = {1'b0, gen_bumped};
        res_status     = STAT_INVALID;
        res_index      = idx_reg;
        res_gen        = gen_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    from_fifo_next = 1'b0;
                    if (s_axis_tuser == CMD_ALLOC) begin
                        if (!fl_empty) begin
                            // reuse the oldest freed slot; pop now, table read next
                            fl_ctrl.pop    = 1'b1;
                            from_fifo_next = 1'b1;
                            state_next     = ST_FIFO;
                        end else begin
                            state_next = ST_EXEC;
                        end
                    end else begin
                        tab_rd_en  = 1'b1;
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_FIFO: begin
                tab_rd_en   = 1'b1;
                tab_rd_addr = fl_pop_idx;
                state_next  = ST_EXEC;
            end
            ST_EXEC: begin
                case (cmd_reg)
                    CMD_ALLOC: begin
                        if (from_fifo_reg) begin
                            res_status  = STAT_OK;
                            res_index   = fl_pop_idx;
                            res_gen     = ent_gen;
                            tab_wr_addr = fl_pop_idx;
                            tab_wr_data = {1'b1, ent_gen};
                        end else if (hw_reg < SLOTS_C) begin
                            res_status  = STAT_OK;
                            res_index   = hw_reg[IDX_W-1:0];
                            res_gen     = GEN_ONE;
                            tab_wr_addr = hw_reg[IDX_W-1:0];
                            tab_wr_data = {1'b1, GEN_ONE};
                        end else begin
                            // no slot left: zero handle, state untouched
                            res_status = STAT_FULL;
                            res_index  = '0;
                            res_gen    = '0;
                        end
                    end
                    CMD_FREE: begin
                        if (live_hit) begin
                            res_status = STAT_OK;
                        end
                    end
                    CMD_CHECK: begin
                        if (live_hit) begin
                            res_status = STAT_OK;
                        end
                    end
                    default: begin
                        res_status = STAT_INVALID;
                    end
                endcase

                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if ((cmd_reg == CMD_ALLOC) && (res_status == STAT_OK)) begin
                        tab_wr_en = 1'b1;
                        live_next = live_reg + 1'b1;
                        if (!from_fifo_reg) begin
                            hw_next = hw_reg + 1'b1;
                        end
                    end
                    if ((cmd_reg == CMD_FREE) && live_hit) begin
                        // bump generation, clear active, queue slot for reuse
                        tab_wr_en    = 1'b1;
                        fl_ctrl.push = 1'b1;
                        if (live_reg != '0) begin
                            live_next = live_reg - 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            from_fifo_reg <= 1'b0;
            hw_reg        <= '0;
            live_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            from_fifo_reg <= from_fifo_next;
            hw_reg        <= hw_next;
            live_reg      <= live_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cmd_reg <= s_axis_tuser;
            idx_reg <= s_index;
            gen_reg <= s_gen;
        end
        if ((state_reg == ST_EXEC) && out_free) begin
            m_status_reg <= res_status;
            m_index_reg  <= res_index;
            m_gen_reg    <= res_gen;
            m_live_reg   <= live_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = M_DATA_W'({m_live_reg, m_gen_reg, m_index_reg});

endmodule

`default_nettype wire

>>> hw/rtl/gsa_slot_mem.sv
`default_nettype none

// Per-slot entry {active, generation}; one write port, one registered read port.
module gsa_slot_mem #(
    parameter int SLOTS    = 1024,
    parameter int GEN_BITS = 16,
    localparam int IDX_W   = $clog2(SLOTS),
    localparam int ENT_W   = GEN_BITS + 1
) (
    input  wire logic             aclk,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [ENT_W-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [ENT_W-1:0] wr_data
);

    logic [ENT_W-1:0] entry_mem [SLOTS];
    logic [ENT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gsa_free_list.sv
`default_nettype none

// FIFO of freed slot indices; pop data is registered and holds until the next pop.
module gsa_free_list #(
    parameter int SLOTS  = 1024,
    localparam int IDX_W = $clog2(SLOTS),
    localparam int CNT_W = $clog2(SLOTS + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gsa_pkg::fl_ctrl_t ctrl,
    input  wire logic [IDX_W-1:0]  push_idx,
    output logic                   empty,
    output logic      [IDX_W-1:0]  pop_idx
);
    import gsa_pkg::*;

    logic [IDX_W-1:0] fifo_mem [SLOTS];
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pop_idx_reg;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.pop) begin
            head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
        end
        if (ctrl.push) begin
            tail_next = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
        end
        // push and pop together leave the count as it is
        if (ctrl.push && !ctrl.pop) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.pop && !ctrl.push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            fifo_mem[tail_reg] <= push_idx;
        end
        if (ctrl.pop) begin
            pop_idx_reg <= fifo_mem[head_reg];
        end
    end

    assign empty   = (count_reg == '0);
    assign pop_idx = pop_idx_reg;

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import gsa_pkg::*;

    localparam int SLOTS    = 1024;
    localparam int GEN_W    = 16;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int S_DATA_W = ((IDX_W + GEN_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((IDX_W + GEN_W + CNT_W + 7) / 8) * 8;
    localparam int M_PAD_W  = M_DATA_W - IDX_W - GEN_W - CNT_W;

    // random part length and flow-control knobs
    localparam int RANDOM_REQS   = 1525;
    localparam int HOLD_AT       = 12;     // result count at which the sink backs off
    localparam int HOLD_CYCLES   = 80;
    localparam int PAUSE_AT      = 500;    // random request before which the source drains
    localparam int IDLE_LIMIT    = 2000;   // cycles without any transfer before giving up
    localparam int MAX_REPORTS   = 20;

    // unused request code; the block must treat it as a no-op
    localparam cmd_t CMD_NOOP_CODE = 2'd3;

    // one expected result, field by field
    typedef struct {
        status_t          status;
        bit [IDX_W-1:0]   index;
        bit [GEN_W-1:0]   generation;
        bit [CNT_W-1:0]   live;
    } grant_result_t;

    // Shadow of the allocator: slot table, free list, counters, and the
    // results still owed by the block in request order.
    class slot_tracker;
        bit [GEN_W-1:0]  gen_of [SLOTS];
        bit              active [SLOTS];
        int unsigned     high_water;
        int unsigned     live;
        bit [IDX_W-1:0]  reuse_q [$];
        grant_result_t   due_results [$];
        int unsigned     errors;

        function new();
            high_water = 0;
            live       = 0;
            errors     = 0;
        endfunction

        function bit is_live(bit [IDX_W-1:0] idx, bit [GEN_W-1:0] gen);
            return gen != 0 && idx < high_water && gen_of[idx] == gen && active[idx];
        endfunction

        // predict the result of an accepted request and update the shadow
        function void note_request(cmd_t cmd, bit [IDX_W-1:0] idx, bit [GEN_W-1:0] gen);
            grant_result_t  r;
            bit [IDX_W-1:0] slot;
            bit             granted;
            r.status     = STAT_INVALID;
            r.index      = idx;
            r.generation = gen;
            case (cmd)
                CMD_ALLOC: begin
                    granted = 1'b1;
                    if (reuse_q.size() != 0) begin
                        slot = reuse_q[0];
                        reuse_q.delete(0);
                    end else if (high_water < SLOTS) begin
                        slot         = high_water[IDX_W-1:0];
                        gen_of[slot] = GEN_W'(1);
                        high_water++;
                    end else begin
                        granted = 1'b0;
                    end
                    if (granted) begin
                        active[slot] = 1'b1;
                        live++;
                        r.status     = STAT_OK;
                        r.index      = slot;
                        r.generation = gen_of[slot];
                    end else begin
                        r.status     = STAT_FULL;
                        r.index      = '0;
                        r.generation = '0;
                    end
                end
                CMD_FREE: begin
                    if (is_live(idx, gen)) begin
                        // generation 0 is reserved, so the bump wraps to 1
                        gen_of[idx] = (gen_of[idx] == '1) ? GEN_W'(1) : gen_of[idx] + 1'b1;
                        active[idx] = 1'b0;
                        reuse_q.insert(reuse_q.size(), idx);
                        if (live != 0) live--;
                        r.status = STAT_OK;
                    end
                end
                CMD_CHECK: begin
                    if (is_live(idx, gen)) r.status = STAT_OK;
                end
                default: ;  // unused code: no-op, reported invalid
            endcase
            r.live = live[CNT_W-1:0];
            due_results.insert(due_results.size(), r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
        endtask

        task check_result(status_t st, logic [M_DATA_W-1:0] data);
            grant_result_t want;
            if (due_results.size() == 0) begin
                report($sformatf("result with none owed: status %0d data %h", st, data));
                return;
            end
            want = due_results[0];
            due_results.delete(0);
            if (st !== want.status)
                report($sformatf("status %0d, want %0d", st, want.status));
            if (data[IDX_W-1:0] !== want.index)
                report($sformatf("index %0d, want %0d", data[IDX_W-1:0], want.index));
            if (data[IDX_W +: GEN_W] !== want.generation)
                report($sformatf("generation %0d, want %0d",
                                 data[IDX_W +: GEN_W], want.generation));
            if (data[IDX_W+GEN_W +: CNT_W] !== want.live)
                report($sformatf("live count %0d, want %0d",
                                 data[IDX_W+GEN_W +: CNT_W], want.live));
            if (data[M_DATA_W-1 -: M_PAD_W] !== '0)
                report($sformatf("pad bits %b not zero", data[M_DATA_W-1 -: M_PAD_W]));
        endtask
    endclass

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;    // in_index, in_generation, zero pad
    cmd_t                s_axis_tuser  = CMD_ALLOC;  // cmd
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;          // out_index, out_generation, live_count, pad
    status_t             m_axis_tuser;          // status

    slot_tracker tracker = new();
    int unsigned idle_cycles = 0;

    generational_slot_allocator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One request transfer. Entered and left at a rising edge; the optional
    // gap drops tvalid first so that idles land between back-to-back items.
    // The shadow is updated here, in the same process that picks the next
    // request, so later picks always see the current state.
    task automatic send_request(cmd_t cmd, bit [IDX_W-1:0] idx, bit [GEN_W-1:0] gen);
        int unsigned gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W - IDX_W - GEN_W){1'b0}}, gen, idx};
        s_axis_tuser  <= cmd;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        tracker.note_request(cmd, idx, gen);
    endtask

    // Source goes quiet until every owed result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Random live handle, by probing used slots; gives up when live slots are scarce.
    function automatic bit find_live(output bit [IDX_W-1:0] idx, output bit [GEN_W-1:0] gen);
        idx = '0;
        gen = '0;
        if (tracker.live == 0) return 1'b0;
        repeat (200) begin
            idx = IDX_W'($urandom_range(0, tracker.high_water - 1));
            if (tracker.active[idx]) begin
                gen = tracker.gen_of[idx];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Mostly well-formed traffic. While fresh slots remain, allocation dominates
    // so the table fills and "no slot left" is reached; after that the mix
    // churns around the full mark with frees, checks, stale handles and noise.
    task automatic random_request();
        int unsigned    r;
        bit             fill;
        bit             found;
        bit [IDX_W-1:0] idx;
        bit [GEN_W-1:0] gen;
        r     = $urandom_range(0, 99);
        fill  = tracker.high_water < SLOTS;
        found = find_live(idx, gen);
        if (r < (fill ? 88 : 30)) begin
            send_request(CMD_ALLOC, IDX_W'($urandom), GEN_W'($urandom));
        end else if (found && r < (fill ? 93 : 60)) begin
            send_request(CMD_FREE, idx, gen);
        end else if (found && r < (fill ? 97 : 80)) begin
            send_request(CMD_CHECK, idx, gen);
        end else if (found && r < (fill ? 98 : 88)) begin
            // stale or future generation of a used slot
            gen = $urandom_range(0, 1) ? gen + 1'b1 : gen - 1'b1;
            send_request($urandom_range(0, 1) ? CMD_FREE : CMD_CHECK, idx, gen);
        end else begin
            send_request(cmd_t'($urandom_range(0, 3)), IDX_W'($urandom), GEN_W'($urandom));
        end
    endtask

    // Result sink: random backpressure per result, plus one long hold-off
    // early on so the single in-flight request stalls the request side.
    initial begin : result_sink
        int unsigned gap;
        int unsigned taken;
        taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = $urandom_range(0, 3);
            if (taken == HOLD_AT) gap = HOLD_CYCLES;
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            tracker.check_result(m_axis_tuser, m_axis_tdata);
            taken++;
        end
    end

    initial begin : request_source
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed: empty table, then basic lifecycle ---
        send_request(CMD_CHECK, 10'd0, 16'd1);        // index never used
        send_request(CMD_FREE,  10'd0, 16'd1);        // free before any allocate
        send_request(CMD_ALLOC, 10'd0, 16'd0);        // slot 0 gen 1
        send_request(CMD_ALLOC, 10'h3FF, 16'hFFFF);   // slot 1; handle fields ignored
        send_request(CMD_ALLOC, 10'd0, 16'd0);        // slot 2
        send_request(CMD_CHECK, 10'd0, 16'd1);        // live
        send_request(CMD_CHECK, 10'd0, 16'd0);        // generation zero never live
        send_request(CMD_CHECK, 10'd1, 16'd2);        // wrong generation
        send_request(CMD_CHECK, 10'h3FF, 16'hFFFF);   // top index, never used
        send_request(CMD_FREE,  10'd1, 16'd1);        // ok, slot 1 goes to the free list
        send_request(CMD_FREE,  10'd1, 16'd1);        // double free: stale handle
        send_request(CMD_CHECK, 10'd1, 16'd2);        // next generation, but not active
        send_request(CMD_NOOP_CODE, 10'h3FF, 16'hFFFF);
        send_request(CMD_ALLOC, 10'd0, 16'd0);        // reuses slot 1 at gen 2
        send_request(CMD_CHECK, 10'd1, 16'd2);
        send_request(CMD_FREE,  10'd0, 16'd1);
        send_request(CMD_FREE,  10'd2, 16'd1);
        send_request(CMD_ALLOC, 10'd0, 16'd0);        // oldest freed first: slot 0
        send_request(CMD_ALLOC, 10'd0, 16'd0);        // then slot 2
        send_request(CMD_ALLOC, 10'd0, 16'd0);        // free list empty: fresh slot 3
        send_request(CMD_FREE,  10'd3, 16'd0);        // generation zero free rejected
        send_request(CMD_NOOP_CODE, 10'd0, 16'd0);
        send_request(CMD_CHECK, 10'd2, 16'd2);
        drain_results();

        // --- random traffic ---
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i == PAUSE_AT) drain_results();
            random_request();
        end

        // --- wind down ---
        s_axis_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
